/* hw/rtl/u8d_pkg.sv */
// Package: shared types and constants of the UTF-8 decoder.
package u8d_pkg;

	localparam int unsigned CP_W        = 21;
	localparam int unsigned PAYLOAD_W   = 7;
	localparam int unsigned QUEUE_DEPTH = 4;

	// Byte class patterns and masks
	localparam logic [7:0] ASCII_MASK  = 8'b1000_0000;
	localparam logic [7:0] CONT_MASK   = 8'b1100_0000;
	localparam logic [7:0] CONT_PAT    = 8'b1000_0000;
	localparam logic [7:0] LEAD2_MASK  = 8'b1110_0000;
	localparam logic [7:0] LEAD2_PAT   = 8'b1100_0000;
	localparam logic [7:0] LEAD3_MASK  = 8'b1111_0000;
	localparam logic [7:0] LEAD3_PAT   = 8'b1110_0000;
	localparam logic [7:0] LEAD4_MASK  = 8'b1111_1000;
	localparam logic [7:0] LEAD4_PAT   = 8'b1111_0000;

	// Payload masks
	localparam logic [7:0] ASCII_BITS  = 8'b0111_1111;
	localparam logic [7:0] LEAD2_BITS  = 8'b0001_1111;
	localparam logic [7:0] LEAD3_BITS  = 8'b0000_1111;
	localparam logic [7:0] LEAD4_BITS  = 8'b0000_0111;
	localparam logic [7:0] CONT_BITS   = 8'b0011_1111;
	localparam int unsigned CONT_SHIFT = 6;

	typedef enum logic [2:0] {
		CLS_ASCII,
		CLS_LEAD2,
		CLS_LEAD3,
		CLS_LEAD4,
		CLS_CONT,
		CLS_BAD
	} byte_class_t;

	typedef struct packed {
		byte_class_t          cls;
		logic [PAYLOAD_W-1:0] payload;
		logic                 fin;
	} item_t;

	typedef struct packed {
		logic [1:0] pending;
		logic       err;
	} back_status_t;

endpackage

/* hw/rtl/u8d_if.sv */
// Interfaces: byte request channel and code point result channel.
interface u8d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       final_byte;

	modport source (output valid, output text_byte, output final_byte, input ready);
	modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface u8d_cp_if;
	logic                       valid;
	logic                       ready;
	logic [u8d_pkg::CP_W-1:0]   code_point;
	logic                       has_code_point;
	logic                       any_error;
	logic                       text_end;

	modport source (output valid, output code_point, output has_code_point,
		output any_error, output text_end, input ready);
	modport sink   (input valid, input code_point, input has_code_point,
		input any_error, input text_end, output ready);
endinterface

/* hw/rtl/u8d_front.sv */
// Front: accepts text bytes and classes each one before it is queued.
module u8d_front (
	u8d_byte_if.sink         text_chan,
	input  logic             push_ready,
	output logic             push_valid,
	output u8d_pkg::item_t   push_item
);

	logic [7:0] b;

	assign b               = text_chan.text_byte;
	assign text_chan.ready = push_ready;
	assign push_valid      = text_chan.valid;

	always_comb begin
		push_item.fin = text_chan.final_byte;
		if ((b & u8d_pkg::ASCII_MASK) == 8'h00) begin
			push_item.cls     = u8d_pkg::CLS_ASCII;
			push_item.payload = u8d_pkg::PAYLOAD_W'(b & u8d_pkg::ASCII_BITS);
		end else if ((b & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_PAT) begin
			push_item.cls     = u8d_pkg::CLS_CONT;
			push_item.payload = u8d_pkg::PAYLOAD_W'(b & u8d_pkg::CONT_BITS);
		end else if ((b & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_PAT) begin
			push_item.cls     = u8d_pkg::CLS_LEAD2;
			push_item.payload = u8d_pkg::PAYLOAD_W'(b & u8d_pkg::LEAD2_BITS);
		end else if ((b & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_PAT) begin
			push_item.cls     = u8d_pkg::CLS_LEAD3;
			push_item.payload = u8d_pkg::PAYLOAD_W'(b & u8d_pkg::LEAD3_BITS);
		end else if ((b & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_PAT) begin
			push_item.cls     = u8d_pkg::CLS_LEAD4;
			push_item.payload = u8d_pkg::PAYLOAD_W'(b & u8d_pkg::LEAD4_BITS);
		end else begin
			push_item.cls     = u8d_pkg::CLS_BAD;
			push_item.payload = '0;
		end
	end

endmodule

/* hw/rtl/u8d_queue.sv */
// Queue: short FIFO of classed bytes between front and back.
module u8d_queue #(
	parameter int unsigned Depth = u8d_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  u8d_pkg::item_t   push_item,
	output logic             pop_valid,
	input  logic             pop,
	output u8d_pkg::item_t   pop_item
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	u8d_pkg::item_t entries_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_item   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/u8d_back.sv */
// Back: sequence state, code point assembly and the output register.
module u8d_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  u8d_pkg::item_t         item,
	output logic                   pop,
	u8d_cp_if.source               code_chan,
	output u8d_pkg::back_status_t  status
);

	logic [u8d_pkg::CP_W-1:0] partial_q, partial_d;
	logic [1:0]               pending_q, pending_d;
	logic                     err_q, err_d;

	logic                     out_valid_q;
	logic [u8d_pkg::CP_W-1:0] cp_q;
	logic                     have_q, err_out_q, end_q;

	logic                     have;
	logic [u8d_pkg::CP_W-1:0] cp;
	logic [u8d_pkg::CP_W-1:0] merged;
	logic                     emit;

	assign pop    = item_valid && (!out_valid_q || code_chan.ready);
	assign merged = {partial_q[u8d_pkg::CP_W-u8d_pkg::CONT_SHIFT-1:0],
		item.payload[u8d_pkg::CONT_SHIFT-1:0]};

	always_comb begin
		partial_d = partial_q;
		pending_d = pending_q;
		err_d     = err_q;
		have      = 1'b0;
		cp        = '0;
		if (pending_q != 2'd0 && item.cls == u8d_pkg::CLS_CONT) begin
			pending_d = pending_q - 2'd1;
			partial_d = merged;
			if (pending_q == 2'd1) begin
				have      = 1'b1;
				cp        = merged;
				partial_d = '0;
			end
		end else begin
			// open sequence broken: drop it, decode this byte as a lead
			if (pending_q != 2'd0) begin
				err_d     = 1'b1;
				pending_d = 2'd0;
				partial_d = '0;
			end
			case (item.cls)
				u8d_pkg::CLS_ASCII: begin
					have = 1'b1;
					cp   = u8d_pkg::CP_W'(item.payload);
				end
				u8d_pkg::CLS_LEAD2: begin
					partial_d = u8d_pkg::CP_W'(item.payload);
					pending_d = 2'd1;
				end
				u8d_pkg::CLS_LEAD3: begin
					partial_d = u8d_pkg::CP_W'(item.payload);
					pending_d = 2'd2;
				end
				u8d_pkg::CLS_LEAD4: begin
					partial_d = u8d_pkg::CP_W'(item.payload);
					pending_d = 2'd3;
				end
				default: begin
					err_d = 1'b1;
				end
			endcase
		end
		if (item.fin && pending_d != 2'd0) begin
			err_d = 1'b1;
		end
		emit = item.fin || have;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pending_q <= 2'd0;
			err_q     <= 1'b0;
		end else if (pop) begin
			if (item.fin) begin
				partial_q <= '0;
				pending_q <= 2'd0;
				err_q     <= 1'b0;
			end else begin
				partial_q <= partial_d;
				pending_q <= pending_d;
				err_q     <= err_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (code_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			cp_q      <= cp;
			have_q    <= have;
			err_out_q <= err_d;
			end_q     <= item.fin;
		end
	end

	assign code_chan.valid          = out_valid_q;
	assign code_chan.code_point     = cp_q;
	assign code_chan.has_code_point = have_q;
	assign code_chan.any_error      = err_out_q;
	assign code_chan.text_end       = end_q;

	assign status.pending = pending_q;
	assign status.err     = err_q;

endmodule

/* hw/rtl/utf8_to_codepoint_decoder.sv */
// Top level: UTF-8 byte stream to code point decoder.
//
//  Channel     Dir  Payload                                          Moves
//  text_chan   in   text_byte[7:0], final_byte                       one byte per request
//  code_chan   out  code_point[20:0], has_code_point, any_error,     zero or one result
//                   text_end                                         per byte
//
// One byte per cycle while code_chan.ready holds; after a byte is accepted its result
// passes through the queue write, then the back end's output register.
// The front classes each byte as it enters the queue; the back end pops one
// queued byte a cycle while its output register is free or being taken, and holds the open sequence state.
// Reset clears queue pointers, sequence state and the output valid; no sweep.
// A stalled result holds the back end; the queue (QueueDepth entries) keeps
// taking bytes until it fills, then text_chan.ready drops.
// A byte with final_byte set always yields a result with text_end and clears
// the sequence state for the next text.
module utf8_to_codepoint_decoder #(
	parameter int unsigned QueueDepth = u8d_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	u8d_byte_if.sink    text_chan,
	u8d_cp_if.source    code_chan
);

	// front -> queue
	logic                   push_valid;
	logic                   push_ready;
	u8d_pkg::item_t         push_item;

	// queue -> back
	logic                   q_valid;
	logic                   q_pop;
	u8d_pkg::item_t         q_item;

	u8d_pkg::back_status_t  back_st;

	u8d_front u_front (
		.text_chan  (text_chan),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_item  (push_item)
	);

	u8d_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_item   (q_item)
	);

	u8d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (q_item),
		.pop        (q_pop),
		.code_chan  (code_chan),
		.status     (back_st)
	);

	// A byte that ends the text leaves the back end clean.
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_item.fin |=> back_st.pending == 2'd0 && !back_st.err)
		else $error("sequence state not cleared after final byte");

	// Mid-text results exist only for completed code points.
	a_mid_has_cp: assert property (@(posedge clk) disable iff (!arst_n)
		code_chan.valid && !code_chan.text_end |-> code_chan.has_code_point)
		else $error("mid-text result without a code point");

	// No code point means a zero value.
	a_cp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		code_chan.valid && !code_chan.has_code_point |-> code_chan.code_point == '0)
		else $error("code point nonzero without has_code_point");

	// An accepted byte is in the queue on the next cycle.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		text_chan.valid && text_chan.ready |=> q_valid)
		else $error("accepted byte missing from queue");

endmodule

/* test/tb.sv */
// Testbench: UTF-8 decoder checked against its own decode predictor, with random stalls.
module tb;

	// Timing and run shape
	localparam int unsigned IDLE_PCT        = 6;    // chance of a gap per cycle, each side
	localparam int unsigned HOLD_OFF_CYCLES = 64;   // long result stall in the pressure test
	localparam int unsigned WATCHDOG_LIMIT  = 1000; // cycles with no handshake at all
	localparam int unsigned DRAIN_CYCLES    = 8;    // result lags its byte by the queue and the output register
	localparam int unsigned PRESSURE_BYTES  = 40;
	localparam int unsigned RANDOM_BYTES    = 1180;
	localparam int unsigned STEADY_BYTES    = 150;

	// Kinds of damage the random texts get
	typedef enum int unsigned {
		NZ_ANY_BYTE,  // any value at all
		NZ_STRAY,     // continuation with no open sequence
		NZ_CUT_SEQ,   // lead plus too few continuations
		NZ_BAD_LEAD   // 11111xxx
	} noise_kind_t;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [u8d_pkg::CP_W-1:0] code_point;
		logic                     has_code_point;
		logic                     any_error;
		logic                     text_end;
	} cp_result_t;

	logic clk = 1'b0;
	logic arst_n;

	u8d_byte_if text_chan ();
	u8d_cp_if   code_chan ();

	utf8_to_codepoint_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_chan (text_chan),
		.code_chan (code_chan)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Decoder state as the predictor sees it
	logic [u8d_pkg::CP_W-1:0] dec_partial;
	logic [1:0]               dec_pending;
	logic                     dec_error;

	cp_result_t expected_cps[$];

	// Shared knobs between the test tasks and the side processes
	bit no_idle;
	bit hold_off_req;

	int unsigned mismatches;
	int unsigned bytes_sent;
	int unsigned n_texts;
	int unsigned n_code_points;
	int unsigned n_error_texts;
	int unsigned quiet_cycles;

	// Predictor: consumes one accepted byte, returns 1 when it yields a result.
	// Mirrors the decode rules: continuation shifts in six bits, anything else
	// while a sequence is open breaks it and is then re-decoded as a lead.
	function automatic bit decode_byte(input logic [7:0] b, input logic fin,
			output cp_result_t res);
		logic                     have;
		logic [u8d_pkg::CP_W-1:0] cp;
		have = 1'b0;
		cp   = '0;
		if (dec_pending != 2'd0 && (b & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_PAT) begin
			dec_partial = (dec_partial << u8d_pkg::CONT_SHIFT)
				| u8d_pkg::CP_W'(b & u8d_pkg::CONT_BITS);
			dec_pending = dec_pending - 2'd1;
			if (dec_pending == 2'd0) begin
				have        = 1'b1;
				cp          = dec_partial;
				dec_partial = '0;
			end
		end else begin
			// broken sequence: drop it and flag the text
			if (dec_pending != 2'd0) begin
				dec_error   = 1'b1;
				dec_pending = 2'd0;
				dec_partial = '0;
			end
			if ((b & u8d_pkg::ASCII_MASK) == 8'd0) begin
				have = 1'b1;
				cp   = u8d_pkg::CP_W'(b & u8d_pkg::ASCII_BITS);
			end else if ((b & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_PAT) begin
				dec_partial = u8d_pkg::CP_W'(b & u8d_pkg::LEAD2_BITS);
				dec_pending = 2'd1;
			end else if ((b & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_PAT) begin
				dec_partial = u8d_pkg::CP_W'(b & u8d_pkg::LEAD3_BITS);
				dec_pending = 2'd2;
			end else if ((b & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_PAT) begin
				dec_partial = u8d_pkg::CP_W'(b & u8d_pkg::LEAD4_BITS);
				dec_pending = 2'd3;
			end else begin
				// stray continuation or 11111xxx lead
				dec_error = 1'b1;
			end
		end
		res.code_point     = cp;
		res.has_code_point = have;
		res.text_end       = fin;
		if (fin) begin
			// truncated text: open sequence at the last byte
			if (dec_pending != 2'd0)
				dec_error = 1'b1;
			res.any_error = dec_error;
			dec_partial   = '0;
			dec_pending   = 2'd0;
			dec_error     = 1'b0;
			return 1'b1;
		end
		res.any_error = dec_error;
		return have;
	endfunction

	// Monitor: predicts on every accepted byte request, checks every accepted
	// result against the oldest expectation. Both handshakes are sampled at the
	// clock edge, so values are the ones that were settled before it.
	always @(posedge clk) begin
		cp_result_t exp_cp;
		cp_result_t got_cp;
		if (arst_n && text_chan.valid && text_chan.ready) begin
			if (decode_byte(text_chan.text_byte, text_chan.final_byte, exp_cp))
				expected_cps.insert(expected_cps.size(), exp_cp);
		end
		if (arst_n && code_chan.valid && code_chan.ready) begin
			got_cp.code_point     = code_chan.code_point;
			got_cp.has_code_point = code_chan.has_code_point;
			got_cp.any_error      = code_chan.any_error;
			got_cp.text_end       = code_chan.text_end;
			if (got_cp.has_code_point === 1'b1)
				n_code_points++;
			if (got_cp.text_end === 1'b1) begin
				n_texts++;
				if (got_cp.any_error === 1'b1)
					n_error_texts++;
			end
			if (expected_cps.size() == 0) begin
				$display("%0t: result with nothing expected: cp=%h has=%b err=%b end=%b",
					$time, got_cp.code_point, got_cp.has_code_point,
					got_cp.any_error, got_cp.text_end);
				mismatches++;
			end else begin
				exp_cp = expected_cps.pop_front();
				if (got_cp.code_point !== exp_cp.code_point) begin
					$display("%0t: code_point expected %h actual %h",
						$time, exp_cp.code_point, got_cp.code_point);
					mismatches++;
				end
				if (got_cp.has_code_point !== exp_cp.has_code_point) begin
					$display("%0t: has_code_point expected %b actual %b",
						$time, exp_cp.has_code_point, got_cp.has_code_point);
					mismatches++;
				end
				if (got_cp.any_error !== exp_cp.any_error) begin
					$display("%0t: any_error expected %b actual %b",
						$time, exp_cp.any_error, got_cp.any_error);
					mismatches++;
				end
				if (got_cp.text_end !== exp_cp.text_end) begin
					$display("%0t: text_end expected %b actual %b",
						$time, exp_cp.text_end, got_cp.text_end);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: a run that stops moving is a failure
	always @(posedge clk) begin
		if ((text_chan.valid && text_chan.ready) || (code_chan.valid && code_chan.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Result side: random stalls, or one long hold-off on request so the
	// internal queue fills and text_chan.ready has to drop.
	initial begin
		code_chan.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				code_chan.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				code_chan.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Sends one byte request and returns at the edge that accepts it. Valid is
	// left high so back-to-back requests never toggle it within one step.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			text_chan.valid <= 1'b0;
			@(posedge clk);
		end
		text_chan.valid      <= 1'b1;
		text_chan.text_byte  <= b;
		text_chan.final_byte <= fin;
		do
			@(posedge clk);
		while (!text_chan.ready);
		bytes_sent++;
	endtask

	// Whole text; only the last byte carries final_byte
	task automatic send_text(input byte_q_t txt);
		foreach (txt[i])
			send_byte(txt[i], i == txt.size() - 1);
	endtask

	// Appends one byte at the tail of a text
	function automatic void add_byte(ref byte_q_t txt, input logic [7:0] b);
		txt.insert(txt.size(), b);
	endfunction

	// Well-formed encoding of the low payload bits of cp in len bytes.
	// No overlong or surrogate rules apply, so any payload is fine.
	function automatic void append_char(ref byte_q_t txt, input int unsigned len,
			input logic [u8d_pkg::CP_W-1:0] cp);
		case (len)
			1: add_byte(txt, {1'b0, cp[6:0]});
			2: begin
				add_byte(txt, {3'b110, cp[10:6]});
				add_byte(txt, {2'b10, cp[5:0]});
			end
			3: begin
				add_byte(txt, {4'b1110, cp[15:12]});
				add_byte(txt, {2'b10, cp[11:6]});
				add_byte(txt, {2'b10, cp[5:0]});
			end
			default: begin
				add_byte(txt, {5'b11110, cp[20:18]});
				add_byte(txt, {2'b10, cp[17:12]});
				add_byte(txt, {2'b10, cp[11:6]});
				add_byte(txt, {2'b10, cp[5:0]});
			end
		endcase
	endfunction

	// Random text: mostly valid characters, noise_pct percent damaged pieces
	task automatic send_random_text(input int unsigned max_chars, input int unsigned noise_pct);
		byte_q_t                  txt;
		int unsigned              n_chars;
		int unsigned              len;
		logic [u8d_pkg::CP_W-1:0] cp;
		noise_kind_t              kind;
		n_chars = $urandom_range(1, max_chars);
		repeat (n_chars) begin
			len = $urandom_range(1, 4);
			cp  = u8d_pkg::CP_W'($urandom);
			if ($urandom_range(99) < noise_pct) begin
				kind = noise_kind_t'($urandom_range(NZ_ANY_BYTE, NZ_BAD_LEAD));
				case (kind)
					NZ_ANY_BYTE: add_byte(txt, 8'($urandom_range(0, 255)));
					NZ_STRAY:    add_byte(txt, {2'b10, cp[5:0]});
					NZ_CUT_SEQ: begin
						len = $urandom_range(2, 4);
						append_char(txt, len, cp);
						repeat ($urandom_range(1, len - 1))
							void'(txt.pop_back());
					end
					default:     add_byte(txt, {5'b11111, cp[2:0]});
				endcase
			end else begin
				append_char(txt, len, cp);
			end
		end
		send_text(txt);
	endtask

	// Extremes of the 1-, 2- and 4-byte sequences, and special cases by hand
	task automatic test_directed();
		// ascii ends, 2/3/4-byte, stray continuation, bad lead, ends on ascii
		send_text('{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
			8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h80, 8'hFF, 8'h41});
		// top 2-byte value, broken 3-byte lead, largest 21-bit value on the last byte
		send_text('{8'hDF, 8'hBF, 8'hE0, 8'h41, 8'hF7, 8'hBF, 8'hBF, 8'hBF});
		// truncated text, then a bad lead as the only byte
		send_text('{8'hC3});
		send_text('{8'hF8});
	endtask

	// Bulk of the stimulus: half clean texts, half with some damage
	task automatic test_random_texts();
		int unsigned stop_at;
		stop_at = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < stop_at)
			send_random_text(12, ($urandom_range(1) != 0) ? 0 : 15);
	endtask

	// Long result stall while bytes keep coming: queue fills, input stalls
	task automatic test_backpressure();
		int unsigned stop_at;
		stop_at      = bytes_sent + PRESSURE_BYTES;
		hold_off_req = 1'b1;
		while (bytes_sent < stop_at)
			send_random_text(12, 0);
	endtask

	// Full rate on both sides for a while
	task automatic test_no_idle();
		int unsigned stop_at;
		stop_at = bytes_sent + STEADY_BYTES;
		no_idle = 1'b1;
		while (bytes_sent < stop_at)
			send_random_text(8, 10);
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n                = 1'b0;
		text_chan.valid      <= 1'b0;
		text_chan.text_byte  <= 8'd0;
		text_chan.final_byte <= 1'b0;
		dec_partial           = '0;
		dec_pending           = 2'd0;
		dec_error             = 1'b0;
		no_idle               = 1'b0;
		hold_off_req          = 1'b0;
		mismatches            = 0;
		bytes_sent            = 0;
		n_texts               = 0;
		n_code_points         = 0;
		n_error_texts         = 0;
		quiet_cycles          = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_backpressure();
		test_random_texts();
		test_no_idle();

		// last request accepted at this edge: drop valid; once its expectation is
		// surely queued, wait for all expectations to be met, then drain
		text_chan.valid <= 1'b0;
		@(posedge clk);
		while (expected_cps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d texts; %0d code points, %0d texts ended in error.",
			bytes_sent, n_texts, n_code_points, n_error_texts);
		$display("Covered a long result stall, random gaps on both sides and a full-rate stretch.");
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
